FILE: rtl/core/bsm_pkg.sv
// Package for the belt speed meter: item structs, config register indexes,
// queue sizing and divider widths. No dependencies.
package bsm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int SCALE_W     = 10;
  localparam int DVD_W       = 32 + SCALE_W;
  localparam int DCNT_W      = $clog2(DVD_W);

  localparam logic [SCALE_W-1:0] SCALE_K = SCALE_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LASER_EN  = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_HYST      = 3'd2,
    REG_SEG_LEN   = 3'd3,
    REG_ROLLER    = 3'd4,
    REG_INTERVAL  = 3'd5
  } cfg_reg_t;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;
    logic [31:0]            time_ms;
  } in_item_t;

  typedef struct packed {
    logic        detecting;
    logic        report_valid;
    logic [31:0] speed_mm_s;
    logic [15:0] segments;
    logic [31:0] duration_ms;
  } out_item_t;

  typedef struct packed {
    logic        laser_enabled;
    logic [9:0]  detect_threshold;
    logic [9:0]  hysteresis;
    logic [15:0] seg_len;
    logic [15:0] roller_gap;
    logic [15:0] interval_ms;
  } cfg_t;

  // Work handed from the front to the back through the queue
  typedef struct packed {
    logic        detecting;
    logic        report;
    logic [15:0] segments;
    logic [31:0] duration;
    logic [31:0] length;
  } job_t;

endpackage

FILE: rtl/core/belt_speed_meter_core.sv
// Top level of the belt speed meter: configuration registers, front end,
// job queue and divider back end. Uses bsm_pkg, bsm_front, bsm_queue, bsm_back.
//
// Each item (sensor sample or restart) yields exactly one result item. The
// front end takes one item per cycle while the four-entry job queue has room;
// the hysteresis classifier, segment counter and report timer update at
// acceptance. The back end sends an item without a report straight to the
// result load; a report passes distance clamp, x1000 multiply, 42 restoring
// divider steps and result load, so the serial divider sets the sustained rate.
// Config registers are written through cfg_*, always ready; indexes beyond
// the last register are ignored.
module belt_speed_meter_core import bsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic push;
  job_t push_data;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.laser_enabled    <= 1'b0;
      cfg_r.detect_threshold <= 10'd512;
      cfg_r.hysteresis       <= 10'd50;
      cfg_r.seg_len          <= 16'd100;
      cfg_r.roller_gap       <= 16'd0;
      cfg_r.interval_ms      <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LASER_EN:  cfg_r.laser_enabled    <= cfg_data[0];
        REG_THRESHOLD: cfg_r.detect_threshold <= cfg_data[9:0];
        REG_HYST:      cfg_r.hysteresis       <= cfg_data[9:0];
        REG_SEG_LEN:   cfg_r.seg_len          <= cfg_data;
        REG_ROLLER:    cfg_r.roller_gap       <= cfg_data;
        REG_INTERVAL:  cfg_r.interval_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  bsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a non-report result carries no measurement
  a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.report_valid) |->
      (out_data.speed_mm_s == 32'd0 && out_data.segments == 16'd0 &&
       out_data.duration_ms == 32'd0))
    else $error("non-report result has nonzero fields");

  // a report never divides by zero and always counts the closing edge
  a_report_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.report_valid) |->
      (out_data.duration_ms != 32'd0 && out_data.segments != 16'd0 &&
       out_data.detecting))
    else $error("report with zero duration or segments");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("job queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty))
    else $error("job queue underflow");
`endif

endmodule

FILE: rtl/core/bsm_front.sv
// Front end: accepts items, runs the hysteresis classifier, segment counter
// and report timing, and pushes one job per item. Uses bsm_pkg.
module bsm_front import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_data,
  input  logic     q_full
);

  logic        obj_r, obj_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [31:0] last_r, last_nxt;

  logic        f_valid_r;
  logic        f_det_r, f_det_nxt;
  logic        f_rep_r, f_rep_nxt;
  logic [15:0] f_segs_r, f_segs_nxt;
  logic [31:0] f_dur_r, f_dur_nxt;

  logic        accept;
  logic [10:0] clear_lvl;
  logic [10:0] smp;
  logic        obj_cls;
  logic [31:0] elapsed;
  logic [15:0] need;
  logic [15:0] seg_inc;

  assign in_ready  = !f_valid_r || !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = f_valid_r && !q_full;

  assign clear_lvl = {1'b0, cfg.detect_threshold} + {1'b0, cfg.hysteresis};
  assign smp       = {1'b0, in_data.sample[9:0]};
  assign elapsed   = in_data.time_ms - last_r;
  assign need      = (cfg.interval_ms == 16'd0) ? 16'd1 : cfg.interval_ms;
  assign seg_inc   = (seg_r == 16'hFFFF) ? seg_r : seg_r + 16'd1;

  always_comb begin
    if (smp < {1'b0, cfg.detect_threshold}) begin
      obj_cls = 1'b1;
    end else if (smp > clear_lvl) begin
      obj_cls = 1'b0;
    end else begin
      obj_cls = obj_r;
    end
  end

  always_comb begin
    obj_nxt    = obj_r;
    seg_nxt    = seg_r;
    last_nxt   = last_r;
    f_rep_nxt  = 1'b0;
    f_segs_nxt = 16'd0;
    f_dur_nxt  = 32'd0;
    if (in_data.command == CMD_RESTART) begin
      seg_nxt  = 16'd0;
      last_nxt = in_data.time_ms;
    end else if (cfg.laser_enabled) begin
      obj_nxt = obj_cls;
      if (obj_cls && !obj_r) begin
        seg_nxt = seg_inc;
        if (elapsed >= {16'd0, need}) begin
          f_rep_nxt  = 1'b1;
          f_segs_nxt = seg_inc;
          f_dur_nxt  = elapsed;
          seg_nxt    = 16'd0;
          last_nxt   = in_data.time_ms;
        end
      end
    end
    f_det_nxt = obj_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_r     <= 1'b0;
      seg_r     <= 16'd0;
      last_r    <= 32'd0;
      f_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        obj_r     <= obj_nxt;
        seg_r     <= seg_nxt;
        last_r    <= last_nxt;
        f_valid_r <= 1'b1;
      end else if (push) begin
        f_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_det_r  <= f_det_nxt;
      f_rep_r  <= f_rep_nxt;
      f_segs_r <= f_segs_nxt;
      f_dur_r  <= f_dur_nxt;
    end
  end

  always_comb begin
    push_data.detecting = f_det_r;
    push_data.report    = f_rep_r;
    push_data.segments  = f_segs_r;
    push_data.duration  = f_dur_r;
    push_data.length    = {16'd0, f_segs_r} * {16'd0, cfg.seg_len};
  end

endmodule

FILE: rtl/core/bsm_queue.sv
// Short job queue between front and back, QDEPTH entries deep.
// Uses bsm_pkg for the job struct and sizing.
module bsm_queue import bsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/bsm_back.sv
// Back end: pops jobs, computes (length - spacing) * 1000 / elapsed with a
// restoring divider one bit per cycle, and holds the result register. Uses bsm_pkg.
module bsm_back import bsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  job_t      pop_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_MUL,
    S_DIV,
    S_PUT
  } state_t;

  state_t            state_r;
  job_t              job_r;
  logic [31:0]       dist_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [31:0]       rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [DVD_W-1:0]  prod;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_diff;
  logic              q_bit;
  logic [31:0]       speed_sat;
  logic              load_out;

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign prod      = {{(DVD_W-32){1'b0}}, dist_r} * {{(DVD_W-SCALE_W){1'b0}}, SCALE_K};
  assign rem_sh    = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff  = rem_sh - {1'b0, job_r.duration};
  assign q_bit     = !rem_diff[32];
  assign speed_sat = (|dvd_r[DVD_W-1:32]) ? 32'hFFFF_FFFF : dvd_r[31:0];
  assign load_out  = (state_r == S_PUT) && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r   <= pop_data;
            state_r <= pop_data.report ? S_SUB : S_PUT;
          end
        end
        S_SUB: begin
          // distance below zero clamps to 0
          dist_r  <= (job_r.length > {16'd0, cfg.roller_gap}) ?
                     job_r.length - {16'd0, cfg.roller_gap} : 32'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          dvd_r   <= prod;
          rem_r   <= 32'd0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= q_bit ? rem_diff[31:0] : rem_sh[31:0];
          dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DCNT_W'(DVD_W-1)) begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (load_out) begin
            out_r.detecting    <= job_r.detecting;
            out_r.report_valid <= job_r.report;
            out_r.speed_mm_s   <= job_r.report ? speed_sat : 32'd0;
            out_r.segments     <= job_r.segments;
            out_r.duration_ms  <= job_r.duration;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/bsm_checker.sv
// Scoreboard for belt_speed_meter_core: follows register writes and accepted
// items, predicts each result item and compares it with what comes out.
// Depends on bsm_pkg.
module bsm_checker import bsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    readings_due
);

  localparam logic [63:0] MS_PER_S   = 64'd1000;
  localparam int          REPORT_MAX = 10;

  cfg_t        regs;
  logic        present;
  logic [15:0] seg_cnt;
  logic [31:0] last_stamp;
  out_item_t   expected_readings[$];

  // Advances the belt state by one item and returns the reading it gives
  function automatic out_item_t measure_item(in_item_t it);
    out_item_t   r;
    logic        was;
    logic [10:0] clear_lvl;
    logic [31:0] elapsed;
    logic [31:0] need;
    logic [63:0] length;
    logic [63:0] net_len;
    logic [63:0] quot;
    r = '0;
    if (it.command == CMD_RESTART) begin
      seg_cnt    = '0;
      last_stamp = it.time_ms;
    end else if (regs.laser_enabled) begin
      was       = present;
      clear_lvl = {1'b0, regs.detect_threshold} + {1'b0, regs.hysteresis};
      if ({1'b0, it.sample} < {1'b0, regs.detect_threshold})
        present = 1'b1;
      else if ({1'b0, it.sample} > clear_lvl)
        present = 1'b0;
      if (present && !was) begin
        elapsed = it.time_ms - last_stamp;
        need    = (regs.interval_ms == '0) ? 32'd1 : {16'd0, regs.interval_ms};
        if (seg_cnt != 16'hFFFF)
          seg_cnt = seg_cnt + 16'd1;
        if (elapsed >= need) begin
          length  = {48'd0, seg_cnt} * {48'd0, regs.seg_len};
          net_len = (length > {48'd0, regs.roller_gap}) ?
                    length - {48'd0, regs.roller_gap} : 64'd0;
          quot    = (net_len * MS_PER_S) / {32'd0, elapsed};
          r.speed_mm_s   = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
          r.segments     = seg_cnt;
          r.duration_ms  = elapsed;
          r.report_valid = 1'b1;
          last_stamp     = it.time_ms;
          seg_cnt        = '0;
        end
      end
    end
    r.detecting = present;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      regs.laser_enabled    = 1'b0;
      regs.detect_threshold = 10'd512;
      regs.hysteresis       = 10'd50;
      regs.seg_len          = 16'd100;
      regs.roller_gap       = 16'd0;
      regs.interval_ms      = 16'd1000;
      present        = 1'b0;
      seg_cnt        = '0;
      last_stamp     = '0;
      mismatch_count = 0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_LASER_EN:  regs.laser_enabled    = cfg_data[0];
          REG_THRESHOLD: regs.detect_threshold = cfg_data[9:0];
          REG_HYST:      regs.hysteresis       = cfg_data[9:0];
          REG_SEG_LEN:   regs.seg_len          = cfg_data;
          REG_ROLLER:    regs.roller_gap       = cfg_data;
          REG_INTERVAL:  regs.interval_ms      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(measure_item(in_data));
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: result item with nothing pending: det=%0b rep=%0b speed=%0d",
                     $time, out_data.detecting, out_data.report_valid,
                     out_data.speed_mm_s);
        end else begin
          want = expected_readings.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("%0t: result differs, expected det=%0b rep=%0b speed=%0d",
                       $time, want.detecting, want.report_valid, want.speed_mm_s);
              $display("    expected segs=%0d dur=%0d",
                       want.segments, want.duration_ms);
              $display("    got det=%0b rep=%0b speed=%0d segs=%0d dur=%0d",
                       out_data.detecting, out_data.report_valid, out_data.speed_mm_s,
                       out_data.segments, out_data.duration_ms);
            end
          end
        end
      end
    end
    readings_due = expected_readings.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for belt_speed_meter_core: clock, reset, item and register
// stimulus, result back-pressure and the verdict. Depends on bsm_pkg,
// bsm_checker and the core.
module tb_top;
  import bsm_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int SAT_EDGES   = 70;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int QUIET_ITEMS = 200;
  localparam int TAIL_CYCLES = 60;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatch_count;
  int                    readings_due;

  // stimulus-side copies of the settings, used only to shape samples and time steps
  int          thr  = 512;
  int          hyst = 50;
  int          intv = 1000;
  logic [31:0] now  = '0;
  bit          lit;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int unsigned cycle_count = 0;

  belt_speed_meter_core u_dut (.*);
  bsm_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off, none when quiet
  initial begin : result_side
    int n;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send(logic cmd, logic [SAMPLE_BITS-1:0] smp, logic [31:0] t);
    int       gap;
    in_item_t it;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    it.command = cmd;
    it.sample  = smp;
    it.time_ms = t;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and let every pending reading come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers carry random junk
  task automatic apply_cfg(bit laser, int t, int h, int s, int r, int v);
    settle();
    write_reg(REG_LASER_EN,  {15'($urandom()), laser});
    write_reg(REG_THRESHOLD, {6'($urandom()), 10'(t)});
    write_reg(REG_HYST,      {6'($urandom()), 10'(h)});
    write_reg(REG_SEG_LEN,   16'(s));
    write_reg(REG_ROLLER,    16'(r));
    write_reg(REG_INTERVAL,  16'(v));
    thr  = t;
    hyst = h;
    intv = v;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] dark_sample();
    return (thr == 0) ? '0 : SAMPLE_BITS'($urandom_range(0, thr - 1));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] light_sample();
    if (thr + hyst >= SAMPLE_MAX)
      return SAMPLE_BITS'(SAMPLE_MAX);
    return SAMPLE_BITS'($urandom_range(thr + hyst + 1, SAMPLE_MAX));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] band_sample();
    int hi;
    hi = (thr + hyst > SAMPLE_MAX) ? SAMPLE_MAX : thr + hyst;
    return SAMPLE_BITS'($urandom_range(thr, hi));
  endfunction

  // mostly a moving belt (alternating dark and light), plus noise and restarts
  task automatic belt_item();
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      17, 18:  step = $urandom_range(0, 2 * intv + 2);
      19:      step = int'($urandom());
      default: step = $urandom_range(0, intv / 4 + 2);
    endcase
    now = now + 32'(step);
    if (pick < 3)
      send(CMD_RESTART, SAMPLE_BITS'($urandom()), now);
    else if (pick < 8)
      send(CMD_SAMPLE, SAMPLE_BITS'($urandom()), now);
    else if (pick < 18)
      send(CMD_SAMPLE, band_sample(), now);
    else begin
      lit = !lit;
      send(CMD_SAMPLE, lit ? light_sample() : dark_sample(), now);
    end
  endtask

  task automatic random_phase(int n_items, bit squeeze);
    int t, h, s, r, v;
    t = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(100, 900);
    h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 120);
    s = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(1, 3000);
    r = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 2000);
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 1;
      2:       v = 65535;
      default: v = $urandom_range(2, 600);
    endcase
    apply_cfg(1'b1, t, h, s, r, v);
    now = $urandom();
    send(CMD_RESTART, SAMPLE_BITS'($urandom()), now);
    if (squeeze)
      hold_req = 1'b1;
    repeat (n_items) belt_item();
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // settings after reset: laser off, samples ignored
    send(CMD_RESTART, SAMPLE_BITS'(SAMPLE_MAX), 32'd7);
    send(CMD_SAMPLE, SAMPLE_BITS'(0), 32'd8);

    apply_cfg(1'b1, 512, 50, 100, 0, 1000);
    send(CMD_RESTART, SAMPLE_BITS'(SAMPLE_MAX), 32'hFFFF_FF00);
    send(CMD_SAMPLE, SAMPLE_BITS'(600), 32'hFFFF_FF00);
    send(CMD_SAMPLE, SAMPLE_BITS'(0), 32'hFFFF_FF0A);
    send(CMD_SAMPLE, SAMPLE_BITS'(540), 32'hFFFF_FF10);
    send(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), 32'hFFFF_FF20);
    // timestamp wraps between the restart and this edge
    send(CMD_SAMPLE, SAMPLE_BITS'(511), 32'h0000_0300);
    send(CMD_SAMPLE, SAMPLE_BITS'(562), 32'h0000_0300);
    send(CMD_SAMPLE, SAMPLE_BITS'(563), 32'h0000_0300);

    // zero interval: an edge with no time elapsed still does not report
    apply_cfg(1'b1, 1023, 0, 0, 65535, 0);
    send(CMD_SAMPLE, SAMPLE_BITS'(1022), 32'h0000_0300);
    send(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), 32'h0000_0300);

    apply_cfg(1'b1, 0, 1023, 0, 65535, 0);
    send(CMD_SAMPLE, SAMPLE_BITS'(0), 32'h0000_0300);
    send(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), 32'h0000_0300);

    // counted length below the roller spacing clamps to zero
    apply_cfg(1'b1, 300, 0, 0, 65535, 0);
    send(CMD_SAMPLE, SAMPLE_BITS'(301), 32'h0000_0300);
    send(CMD_SAMPLE, SAMPLE_BITS'(299), 32'h0000_0301);

    apply_cfg(1'b1, 300, 0, 65535, 0, 65535);
    send(CMD_SAMPLE, SAMPLE_BITS'(301), 32'h0000_0301);
    send(CMD_SAMPLE, SAMPLE_BITS'(299), 32'h0000_0301 + 32'd65535);

    // restart still acts with the laser off
    apply_cfg(1'b0, 300, 0, 65535, 0, 65535);
    send(CMD_RESTART, SAMPLE_BITS'(0), 32'hFFFF_FFFF);
    send(CMD_SAMPLE, SAMPLE_BITS'(0), 32'd5);

    for (int p = 0; p < PHASES; p++)
      random_phase(PHASE_ITEMS, p == 1);

    quiet = 1'b1;
    random_phase(QUIET_ITEMS, 1'b0);

    // pile up segments at zero elapsed time, then report them
    // after 1 ms so the speed overflows
    apply_cfg(1'b1, 512, 50, 65535, 0, 1);
    now = $urandom();
    send(CMD_RESTART, SAMPLE_BITS'(0), now);
    repeat (SAT_EDGES) begin
      send(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), now);
      send(CMD_SAMPLE, SAMPLE_BITS'(0), now);
    end
    send(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), now + 32'd1);
    send(CMD_SAMPLE, SAMPLE_BITS'(0), now + 32'd1);

    settle();
    if (mismatch_count == 0 && readings_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_front.sv
rtl/core/bsm_queue.sv
rtl/core/bsm_back.sv
rtl/core/belt_speed_meter_core.sv
sim/bsm_checker.sv
sim/tb_top.sv
